// ----- src/dtdt_pkg.sv -----
// Shared types, register codes and constants for the debounced toggle drive tick block.
package dtdt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CNT_W      = 8;
    localparam int ELAPSED_W  = 11;
    localparam int SERVO_W    = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_LIMIT = 3'd0,
        CFG_RED_IDLE       = 3'd1,
        CFG_RED_WALK       = 3'd2,
        CFG_GREEN_BASE     = 3'd3,
        CFG_LED_ON         = 3'd4
    } t_cfg_reg;

    localparam logic [CNT_W-1:0]     RST_DEBOUNCE_LIMIT = 8'd50;
    localparam logic [ELAPSED_W-1:0] RST_RED_IDLE       = 11'd1000;
    localparam logic [ELAPSED_W-1:0] RST_RED_WALK       = 11'd200;
    localparam logic [ELAPSED_W-1:0] RST_GREEN_BASE     = 11'd50;
    localparam logic [ELAPSED_W-1:0] RST_LED_ON         = 11'd1;

    localparam logic [CNT_W-1:0]     CNT_MAX     = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    localparam int SERVO_STOP = 90;
    localparam int SERVO_TOP  = 255;

    // Division by 15 as a multiply by ceil(2^16 / 15) and a shift of 16.
    // Exact for dividends below 4096, which covers ADC widths up to 12 bits.
    localparam int              POWER_RECIP_W = 13;
    localparam logic [12:0]     POWER_RECIP   = 13'd4370;
    localparam int              POWER_SHIFT   = 16;

endpackage

// ----- src/dtdt_ifs.sv -----
// Handshake interfaces for the sample, result and configuration channels.
interface dtdt_in_if #(
    parameter int ADC_BITS = 10
);
    logic                valid;
    logic                ready;
    logic                switch_pin;
    logic [ADC_BITS-1:0] speed_adc;
    logic [ADC_BITS-1:0] slider_adc;

    modport source (output valid, output switch_pin, output speed_adc, output slider_adc,
                    input ready);
    modport sink   (input valid, input switch_pin, input speed_adc, input slider_adc,
                    output ready);
endinterface

interface dtdt_out_if;
    logic                          valid;
    logic                          ready;
    logic [dtdt_pkg::SERVO_W-1:0]  left_servo;
    logic [dtdt_pkg::SERVO_W-1:0]  right_servo;
    logic                          green_on;
    logic                          red_on;
    logic                          walk_active;

    modport source (output valid, output left_servo, output right_servo, output green_on,
                    output red_on, output walk_active, input ready);
    modport sink   (input valid, input left_servo, input right_servo, input green_on,
                    input red_on, input walk_active, output ready);
endinterface

interface dtdt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dtdt_pkg::CFG_IDX_W-1:0]   index;
    logic [dtdt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/debounced_toggle_drive_tick_unit.sv -----
// Top level: switch debounce, walk mode toggle, servo drive and LED blink timers.
//
// Usage: each request on i_in is one 1 ms tick carrying the active-low switch level
// and the speed and slider ADC readings. Every request yields exactly one result on
// o_out with both servo commands, both LED levels and the walk mode flag.
// A request accepted on i_in is held in the sample register and moves on to the result
// register, and so to o_out, when the result register is free or being drained. One
// request is taken every cycle while o_out is not stalled; the rate is set by the single
// update of the debounce, walk and blink state, which is combinational between the
// sample register and the result register.
// The configuration channel i_cfg is always ready; writes take effect for requests
// processed after the write and should be issued only while no request is in flight.
// Indexes that name no register are ignored.
// Reset (synchronous, active low) clears all tick state, empties both register
// stages and loads the register defaults. When the receiver holds o_out.ready low,
// the result stays on o_out, one further request is held in the sample register,
// and i_in.ready falls until the result is taken.
module debounced_toggle_drive_tick_unit #(
    parameter int ADC_BITS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dtdt_in_if.sink      i_in,
    dtdt_out_if.source   o_out,
    dtdt_cfg_if.sink     i_cfg
);

    localparam int PWR_W   = ADC_BITS - 3;
    localparam int PROD_W  = ADC_BITS + dtdt_pkg::POWER_RECIP_W;
    localparam int DIFF_W  = ADC_BITS + 1;
    localparam int MUL_W   = PWR_W + 1 + DIFF_W;
    localparam int GRN_W   = ((ADC_BITS - 1 > dtdt_pkg::ELAPSED_W) ?
                              ADC_BITS - 1 : dtdt_pkg::ELAPSED_W) + 1;
    localparam int SUM_W   = ((PWR_W + 1 > 9) ? PWR_W + 1 : 9) + 1;
    localparam int ADC_MID = 1 << (ADC_BITS - 1);

    localparam logic [ADC_BITS-1:0]      ADC_MAX   = '1;
    localparam logic signed [DIFF_W-1:0] MID_S     = DIFF_W'(ADC_MID);
    localparam logic signed [MUL_W-1:0]  TRUNC_ADJ = MUL_W'(ADC_MID - 1);
    localparam logic signed [SUM_W-1:0]  SERVO_MID = SUM_W'(dtdt_pkg::SERVO_STOP);
    localparam logic signed [SUM_W-1:0]  SERVO_TOP = SUM_W'(dtdt_pkg::SERVO_TOP);

    // Configuration registers.
    logic [dtdt_pkg::CNT_W-1:0]     r_debounce_limit;
    logic [dtdt_pkg::ELAPSED_W-1:0] r_red_idle_period;
    logic [dtdt_pkg::ELAPSED_W-1:0] r_red_walk_period;
    logic [dtdt_pkg::ELAPSED_W-1:0] r_green_base_period;
    logic [dtdt_pkg::ELAPSED_W-1:0] r_led_on_period;

    // Tick state.
    logic                           r_last_raw;
    logic [dtdt_pkg::CNT_W-1:0]     r_run_count;
    logic                           r_debounced;
    logic                           r_walk_mode;
    logic                           r_green_state;
    logic                           r_red_state;
    logic [dtdt_pkg::ELAPSED_W-1:0] r_green_elapsed;
    logic [dtdt_pkg::ELAPSED_W-1:0] r_red_elapsed;

    // Sample register.
    logic                           r_s1_valid;
    logic                           r_s1_pressed;
    logic [ADC_BITS-1:0]            r_s1_speed;
    logic [PWR_W-1:0]               r_s1_power;
    logic signed [DIFF_W-1:0]       r_s1_diff;

    // Result register.
    logic                           r_out_valid;
    logic [dtdt_pkg::SERVO_W-1:0]   r_left_servo;
    logic [dtdt_pkg::SERVO_W-1:0]   r_right_servo;
    logic                           r_green_on;
    logic                           r_red_on;
    logic                           r_walk_active;

    logic                           w_in_accept;
    logic                           w_s1_adv;
    logic [ADC_BITS-1:0]            w_inv_speed;
    logic [PROD_W-1:0]              w_power_prod;
    logic [PWR_W-1:0]               n_power;

    logic [dtdt_pkg::CNT_W-1:0]     w_count;
    logic [dtdt_pkg::CNT_W-1:0]     n_run_count;
    logic                           n_debounced;
    logic                           n_walk_mode;
    logic signed [MUL_W-1:0]        w_mul;
    logic signed [MUL_W-1:0]        w_mul_adj;
    logic signed [MUL_W-1:0]        w_mul_shift;
    logic signed [PWR_W:0]          w_drive;
    logic signed [SUM_W-1:0]        w_left;
    logic signed [SUM_W-1:0]        w_right;
    logic [GRN_W-1:0]               w_green_period;
    logic [GRN_W-1:0]               w_red_period;
    logic [dtdt_pkg::ELAPSED_W:0]   w_green_blink;
    logic [dtdt_pkg::ELAPSED_W:0]   w_red_blink;

    // One blink timer step; returns {new LED level, new elapsed count}.
    function automatic logic [dtdt_pkg::ELAPSED_W:0] blink_step(
        input logic                           led,
        input logic [dtdt_pkg::ELAPSED_W-1:0] elapsed,
        input logic [GRN_W-1:0]               period
    );
        logic [dtdt_pkg::ELAPSED_W-1:0] e;
        e = (elapsed == dtdt_pkg::ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
        if (GRN_W'(e) > period) begin
            blink_step = {~led, {dtdt_pkg::ELAPSED_W{1'b0}}};
        end else begin
            blink_step = {led, e};
        end
    endfunction

    function automatic logic [dtdt_pkg::SERVO_W-1:0] servo_clip(
        input logic signed [SUM_W-1:0] v
    );
        priority if (v < 0) begin
            servo_clip = '0;
        end else if (v > SERVO_TOP) begin
            servo_clip = '1;
        end else begin
            servo_clip = v[dtdt_pkg::SERVO_W-1:0];
        end
    endfunction

    assign w_s1_adv    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || w_s1_adv;
    assign w_in_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // The speed-to-power division runs ahead of the sample register.
    assign w_inv_speed  = ADC_MAX - i_in.speed_adc;
    assign w_power_prod = PROD_W'(w_inv_speed) * PROD_W'(dtdt_pkg::POWER_RECIP);
    assign n_power      = w_power_prod[dtdt_pkg::POWER_SHIFT +: PWR_W];

    always_comb begin
        // Debounce on the pressed level.
        if (r_s1_pressed == r_last_raw) begin
            w_count = (r_run_count == dtdt_pkg::CNT_MAX) ? r_run_count : r_run_count + 1'b1;
        end else begin
            w_count = '0;
        end
        if (w_count > r_debounce_limit) begin
            n_debounced = r_s1_pressed;
            n_run_count = r_debounce_limit + 1'b1;
        end else begin
            n_debounced = r_debounced;
            n_run_count = w_count;
        end

        // Releasing the debounced switch toggles walk mode.
        n_walk_mode = r_walk_mode ^ (r_debounced & ~n_debounced);

        // Signed divide by a power of two, truncating toward zero.
        w_mul       = MUL_W'($signed({1'b0, r_s1_power})) * MUL_W'(r_s1_diff);
        w_mul_adj   = (w_mul < 0) ? w_mul + TRUNC_ADJ : w_mul;
        w_mul_shift = w_mul_adj >>> (ADC_BITS - 1);
        w_drive     = n_walk_mode ? w_mul_shift[PWR_W:0] : '0;
        w_left      = SERVO_MID + SUM_W'(w_drive);
        w_right     = SERVO_MID - SUM_W'(w_drive);

        w_green_period = r_green_state ? GRN_W'(r_led_on_period) :
                         GRN_W'(r_green_base_period) + GRN_W'(r_s1_speed >> 1);
        w_red_period   = r_red_state ? GRN_W'(r_led_on_period) :
                         (n_walk_mode ? GRN_W'(r_red_walk_period) : GRN_W'(r_red_idle_period));
        w_green_blink  = blink_step(r_green_state, r_green_elapsed, w_green_period);
        w_red_blink    = blink_step(r_red_state, r_red_elapsed, w_red_period);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_limit    <= dtdt_pkg::RST_DEBOUNCE_LIMIT;
            r_red_idle_period   <= dtdt_pkg::RST_RED_IDLE;
            r_red_walk_period   <= dtdt_pkg::RST_RED_WALK;
            r_green_base_period <= dtdt_pkg::RST_GREEN_BASE;
            r_led_on_period     <= dtdt_pkg::RST_LED_ON;
        end else if (i_cfg.valid) begin
            unique case (dtdt_pkg::t_cfg_reg'(i_cfg.index))
                dtdt_pkg::CFG_DEBOUNCE_LIMIT: r_debounce_limit <= i_cfg.data[dtdt_pkg::CNT_W-1:0];
                dtdt_pkg::CFG_RED_IDLE:       r_red_idle_period   <= i_cfg.data;
                dtdt_pkg::CFG_RED_WALK:       r_red_walk_period   <= i_cfg.data;
                dtdt_pkg::CFG_GREEN_BASE:     r_green_base_period <= i_cfg.data;
                dtdt_pkg::CFG_LED_ON:         r_led_on_period     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_pressed <= ~i_in.switch_pin;
            r_s1_speed   <= i_in.speed_adc;
            r_s1_power   <= n_power;
            r_s1_diff    <= $signed({1'b0, i_in.slider_adc}) - MID_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw      <= 1'b0;
            r_run_count     <= '0;
            r_debounced     <= 1'b0;
            r_walk_mode     <= 1'b0;
            r_green_state   <= 1'b0;
            r_red_state     <= 1'b0;
            r_green_elapsed <= '0;
            r_red_elapsed   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_last_raw      <= r_s1_pressed;
                r_run_count     <= n_run_count;
                r_debounced     <= n_debounced;
                r_walk_mode     <= n_walk_mode;
                r_green_state   <= w_green_blink[dtdt_pkg::ELAPSED_W];
                r_green_elapsed <= w_green_blink[dtdt_pkg::ELAPSED_W-1:0];
                r_red_state     <= w_red_blink[dtdt_pkg::ELAPSED_W];
                r_red_elapsed   <= w_red_blink[dtdt_pkg::ELAPSED_W-1:0];
                r_out_valid     <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_left_servo  <= servo_clip(w_left);
            r_right_servo <= servo_clip(w_right);
            r_green_on    <= w_green_blink[dtdt_pkg::ELAPSED_W];
            r_red_on      <= w_red_blink[dtdt_pkg::ELAPSED_W];
            r_walk_active <= n_walk_mode;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.left_servo  = r_left_servo;
    assign o_out.right_servo = r_right_servo;
    assign o_out.green_on    = r_green_on;
    assign o_out.red_on      = r_red_on;
    assign o_out.walk_active = r_walk_active;

endmodule

// ----- src/dtdt_checker.sv -----
// Port-level checker for the debounced toggle drive tick block, with its bind.
module dtdt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [dtdt_pkg::SERVO_W-1:0]  i_left_servo,
    input logic [dtdt_pkg::SERVO_W-1:0]  i_right_servo,
    input logic                          i_green_on,
    input logic                          i_red_on,
    input logic                          i_walk_active
);

    // A stalled result holds until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_left_servo) &&
        $stable(i_right_servo) && $stable(i_green_on) && $stable(i_red_on) &&
        $stable(i_walk_active))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Outside walk mode both servos sit at the stop command.
    a_idle_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_walk_active |->
        i_left_servo == 8'(dtdt_pkg::SERVO_STOP) && i_right_servo == 8'(dtdt_pkg::SERVO_STOP))
        else $error("servo moving while walk mode is off");

    // Unclipped commands are mirrored around the stop command.
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_left_servo != 8'd0 && i_left_servo != 8'd255 &&
        i_right_servo != 8'd0 && i_right_servo != 8'd255 |->
        9'(i_left_servo) + 9'(i_right_servo) == 9'(2 * dtdt_pkg::SERVO_STOP))
        else $error("left and right servo commands not mirrored");

endmodule

bind debounced_toggle_drive_tick_unit dtdt_checker u_dtdt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_left_servo  (o_out.left_servo),
    .i_right_servo (o_out.right_servo),
    .i_green_on    (o_out.green_on),
    .i_red_on      (o_out.red_on),
    .i_walk_active (o_out.walk_active)
);
